[rtl/ipu_pkg.sv]
// ----------------------------------------------------------------------------
// ipu_pkg
// Shared types and constants of the integer pixel upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package ipu_pkg;

  localparam int unsigned MAX_WIDTH   = 4096;
  localparam int unsigned MAX_SCALE   = 8;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned PIXEL_W = 24;
  localparam int unsigned SCALE_W = 4;
  localparam int unsigned SWIDTH_W = 13;
  localparam int unsigned ROWS_W  = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE        = 2'd0,
    REG_SOURCE_WIDTH = 2'd1,
    REG_SOURCE_ROWS  = 2'd2
  } reg_idx_e;

  typedef enum logic {
    OP_SOURCE = 1'b0,
    OP_REPLAY = 1'b1
  } op_e;

  typedef struct packed {
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       image_end;
    logic       rejected;
  } cmd_flags_t;

endpackage

`default_nettype wire

[rtl/integer_pixel_upscaler_core.sv]
// ----------------------------------------------------------------------------
// integer_pixel_upscaler_core
// Nearest-neighbor integer upscaler: front checks and tracks items and the
// line store, a command queue decouples it from the copy expander.
// An accepted item passes the command register, queue and output register.
// One result per cycle while pop is held; an in-phase item yields scale
// results, so items enter every cycle at scale 1, paced by pops otherwise.
// Reset clears counters, phase, queue and registers (scale, width, rows = 1);
// the line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_pixel_upscaler_core #(
  parameter int unsigned MAX_WIDTH = ipu_pkg::MAX_WIDTH,
  parameter int unsigned MAX_SCALE = ipu_pkg::MAX_SCALE,
  localparam int unsigned SW = $clog2(MAX_SCALE + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ipu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ipu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic                           op_i,
  input  wire logic [ipu_pkg::PIXEL_W-1:0]    pixel_in_i,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [ipu_pkg::PIXEL_W-1:0]         pixel_out_o,
  output logic                                last_o,
  output logic                                row_end_o,
  output logic [1:0]                          pad_bytes_o,
  output logic                                image_end_o,
  output logic                                rejected_o
);

  localparam int unsigned QW = ipu_pkg::PIXEL_W + SW + $bits(ipu_pkg::cmd_flags_t);

  logic [ipu_pkg::SCALE_W-1:0]  scale_q;
  logic [ipu_pkg::SWIDTH_W-1:0] width_q;
  logic [ipu_pkg::ROWS_W-1:0]   rows_q;

  logic                        cmd_valid, q_full, q_empty, q_pop;
  logic [ipu_pkg::PIXEL_W-1:0] cmd_pixel, head_pixel;
  logic [SW-1:0]               cmd_count, head_count;
  ipu_pkg::cmd_flags_t         cmd_flags, head_flags;
  logic [QW-1:0]               q_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ipu_pkg::SCALE_W'(1);
      width_q <= ipu_pkg::SWIDTH_W'(1);
      rows_q  <= ipu_pkg::ROWS_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ipu_pkg::reg_idx_e'(cfg_index_i))
        ipu_pkg::REG_SCALE:        scale_q <= cfg_data_i[ipu_pkg::SCALE_W-1:0];
        ipu_pkg::REG_SOURCE_WIDTH: width_q <= cfg_data_i[ipu_pkg::SWIDTH_W-1:0];
        ipu_pkg::REG_SOURCE_ROWS:  rows_q  <= cfg_data_i[ipu_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  ipu_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_SCALE(MAX_SCALE)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .op_i          (op_i),
    .pixel_i       (pixel_in_i),
    .scale_i       (scale_q),
    .source_width_i(width_q),
    .source_rows_i (rows_q),
    .cmd_valid_o   (cmd_valid),
    .cmd_full_i    (q_full),
    .cmd_pixel_o   (cmd_pixel),
    .cmd_count_o   (cmd_count),
    .cmd_flags_o   (cmd_flags)
  );

  ipu_fifo #(
    .WIDTH(QW),
    .DEPTH(ipu_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_valid),
    .wdata_i({cmd_pixel, cmd_count, cmd_flags}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  assign {head_pixel, head_count, head_flags} = q_rdata;

  ipu_back #(
    .MAX_SCALE(MAX_SCALE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(q_empty),
    .cmd_pixel_i(head_pixel),
    .cmd_count_i(head_count),
    .cmd_flags_i(head_flags),
    .cmd_pop_o  (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .pixel_out_o(pixel_out_o),
    .last_o     (last_o),
    .row_end_o  (row_end_o),
    .pad_bytes_o(pad_bytes_o),
    .image_end_o(image_end_o),
    .rejected_o (rejected_o)
  );

endmodule

`default_nettype wire

[rtl/ipu_ram.sv]
// ----------------------------------------------------------------------------
// ipu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ipu_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/ipu_front.sv]
// ----------------------------------------------------------------------------
// ipu_front
// Accepts items, checks phase, tracks column/repeat/row and the line store,
// and issues one expansion command per item.
// ----------------------------------------------------------------------------
`default_nettype none

module ipu_front #(
  parameter int unsigned MAX_WIDTH = ipu_pkg::MAX_WIDTH,
  parameter int unsigned MAX_SCALE = ipu_pkg::MAX_SCALE,
  localparam int unsigned SW = $clog2(MAX_SCALE + 1),
  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int unsigned RW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  output logic                               full_o,
  input  wire logic                          op_i,
  input  wire logic [ipu_pkg::PIXEL_W-1:0]   pixel_i,
  input  wire logic [ipu_pkg::SCALE_W-1:0]   scale_i,
  input  wire logic [ipu_pkg::SWIDTH_W-1:0]  source_width_i,
  input  wire logic [ipu_pkg::ROWS_W-1:0]    source_rows_i,
  output logic                               cmd_valid_o,
  input  wire logic                          cmd_full_i,
  output logic [ipu_pkg::PIXEL_W-1:0]        cmd_pixel_o,
  output logic [SW-1:0]                      cmd_count_o,
  output ipu_pkg::cmd_flags_t                cmd_flags_o
);

  logic [CW-1:0]             column_q, column_d;
  logic [RW-1:0]             repeat_q, repeat_d;
  logic [ipu_pkg::ROWS_W-1:0] row_q, row_d;
  logic                      phase_q, phase_d;

  logic                      s1_valid_q;
  logic                      s1_from_ram_q;
  logic [ipu_pkg::PIXEL_W-1:0] s1_pixel_q;
  logic [SW-1:0]             s1_count_q;
  ipu_pkg::cmd_flags_t       s1_flags_q;

  logic        accept;
  logic        in_phase;
  logic [31:0] s32, w32, rows32, col32;
  logic        row_done, last_row, last_repeat;
  logic [5:0]  pad_prod;
  logic [1:0]  pad;
  logic [CW-1:0] col_addr;
  logic        ram_we, ram_re;
  logic [ipu_pkg::PIXEL_W-1:0] ram_rdata;
  ipu_pkg::cmd_flags_t flags_d;

  assign full_o   = s1_valid_q && cmd_full_i;
  assign accept   = push_i && !full_o;
  assign in_phase = (op_i == phase_q);

  always_comb begin
    if (scale_i == '0) begin
      s32 = 32'd1;
    end else if (32'(scale_i) > MAX_SCALE) begin
      s32 = MAX_SCALE;
    end else begin
      s32 = 32'(scale_i);
    end
    if (source_width_i == '0) begin
      w32 = 32'd1;
    end else if (32'(source_width_i) > MAX_WIDTH) begin
      w32 = MAX_WIDTH;
    end else begin
      w32 = 32'(source_width_i);
    end
    rows32 = (source_rows_i == '0) ? 32'd1 : 32'(source_rows_i);
    col32  = (32'(column_q) >= w32) ? (w32 - 32'd1) : 32'(column_q);
    row_done = (col32 + 32'd1 >= w32);
    last_row = (32'(row_q) + 32'd1 >= rows32);
    if (op_i == ipu_pkg::OP_SOURCE) begin
      last_repeat = (s32 == 32'd1);
    end else begin
      last_repeat = (32'(repeat_q) + 32'd2 >= s32);
    end
    pad_prod = 6'(w32[1:0]) * 6'(s32[1:0]) * 6'd3;
    pad      = 2'(6'd0 - pad_prod);
    col_addr = col32[CW-1:0];
  end

  assign ram_we = accept && in_phase && (op_i == ipu_pkg::OP_SOURCE);
  assign ram_re = accept && in_phase && (op_i == ipu_pkg::OP_REPLAY);

  ipu_ram #(
    .WIDTH(ipu_pkg::PIXEL_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(col_addr),
    .wdata_i(pixel_i),
    .re_i   (ram_re),
    .raddr_i(col_addr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    column_d = column_q;
    repeat_d = repeat_q;
    row_d    = row_q;
    phase_d  = phase_q;
    if (accept && in_phase) begin
      if (!row_done) begin
        column_d = CW'(col32 + 32'd1);
      end else begin
        column_d = '0;
        if ((op_i == ipu_pkg::OP_SOURCE) && !last_repeat) begin
          phase_d  = 1'b1;
          repeat_d = '0;
        end else if (last_repeat) begin
          phase_d  = 1'b0;
          repeat_d = '0;
          row_d    = last_row ? '0 : row_q + 1'b1;
        end else begin
          repeat_d = repeat_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    flags_d = '0;
    if (!in_phase) begin
      flags_d.rejected = 1'b1;
    end else begin
      flags_d.row_end   = row_done;
      flags_d.pad_bytes = row_done ? pad : 2'd0;
      flags_d.image_end = row_done && last_row && last_repeat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q   <= '0;
      repeat_q   <= '0;
      row_q      <= '0;
      phase_q    <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      column_q   <= column_d;
      repeat_q   <= repeat_d;
      row_q      <= row_d;
      phase_q    <= phase_d;
      s1_valid_q <= accept || (s1_valid_q && cmd_full_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_from_ram_q <= in_phase && (op_i == ipu_pkg::OP_REPLAY);
      s1_pixel_q    <= in_phase ? pixel_i : '0;
      s1_count_q    <= in_phase ? SW'(s32) : SW'(1);
      s1_flags_q    <= flags_d;
    end
  end

  assign cmd_valid_o = s1_valid_q;
  assign cmd_pixel_o = s1_from_ram_q ? ram_rdata : s1_pixel_q;
  assign cmd_count_o = s1_count_q;
  assign cmd_flags_o = s1_flags_q;

endmodule

`default_nettype wire

[rtl/ipu_fifo.sv]
// ----------------------------------------------------------------------------
// ipu_fifo
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module ipu_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = ipu_pkg::QUEUE_DEPTH,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned NW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [NW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = data_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[rtl/ipu_back.sv]
// ----------------------------------------------------------------------------
// ipu_back
// Expands each command into its pixel copies, one result per cycle while
// results are popped, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipu_back #(
  parameter int unsigned MAX_SCALE = ipu_pkg::MAX_SCALE,
  localparam int unsigned SW = $clog2(MAX_SCALE + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cmd_empty_i,
  input  wire logic [ipu_pkg::PIXEL_W-1:0] cmd_pixel_i,
  input  wire logic [SW-1:0]               cmd_count_i,
  input  wire ipu_pkg::cmd_flags_t         cmd_flags_i,
  output logic                             cmd_pop_o,
  output logic                             empty_o,
  input  wire logic                        pop_i,
  output logic [ipu_pkg::PIXEL_W-1:0]      pixel_out_o,
  output logic                             last_o,
  output logic                             row_end_o,
  output logic [1:0]                       pad_bytes_o,
  output logic                             image_end_o,
  output logic                             rejected_o
);

  logic          out_valid_q;
  logic [SW-1:0] copy_q;
  logic          load, take, fin;

  logic [ipu_pkg::PIXEL_W-1:0] pixel_q;
  logic       last_q, row_end_q, image_end_q, rejected_q;
  logic [1:0] pad_q;

  assign load      = !out_valid_q || pop_i;
  assign take      = load && !cmd_empty_i;
  assign fin       = (copy_q == cmd_count_i - 1'b1);
  assign cmd_pop_o = take && fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      copy_q      <= '0;
    end else begin
      if (load) begin
        out_valid_q <= !cmd_empty_i;
      end
      if (take) begin
        copy_q <= fin ? '0 : copy_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pixel_q     <= cmd_pixel_i;
      last_q      <= fin;
      row_end_q   <= fin && cmd_flags_i.row_end;
      pad_q       <= (fin && cmd_flags_i.row_end) ? cmd_flags_i.pad_bytes : 2'd0;
      image_end_q <= fin && cmd_flags_i.image_end;
      rejected_q  <= cmd_flags_i.rejected;
    end
  end

  assign empty_o     = !out_valid_q;
  assign pixel_out_o = pixel_q;
  assign last_o      = last_q;
  assign row_end_o   = row_end_q;
  assign pad_bytes_o = pad_q;
  assign image_end_o = image_end_q;
  assign rejected_o  = rejected_q;

endmodule

`default_nettype wire

[dv/tb_integer_pixel_upscaler_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_pixel_upscaler_core
// Self-checking bench for the nearest-neighbor pixel upscaler. A short table of
// directed items and register writes comes first, then random images with
// mostly in-phase source/replay sequences and some out-of-phase noise. Every
// result is compared field by field against an in-bench model of the
// line store and row/repeat counters. Both ports idle at random, and the
// result side holds off once for a long stretch so the input backs up.
// ----------------------------------------------------------------------------

module tb_integer_pixel_upscaler_core;
  import ipu_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned RANDOM_ITEMS = 200;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               last;
    logic               row_end;
    logic [1:0]         pad;
    logic               image_end;
    logic               rejected;
  } px_res_t;

  typedef struct {
    bit                  is_cfg;
    reg_idx_e            idx;
    logic [CFG_DATA_W-1:0] data;
    op_e                 op;
    logic [PIXEL_W-1:0]  pix;
    bit                  typed;
    px_res_t             want;
  } stim_row_t;

  localparam px_res_t REJECT_RES = '{pixel: '0, last: 1'b1, row_end: 1'b0, pad: 2'd0,
                                     image_end: 1'b0, rejected: 1'b1};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic                  op_i = 1'b0;
  logic [PIXEL_W-1:0]    pixel_in_i = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [PIXEL_W-1:0]    pixel_out_o;
  logic                  last_o;
  logic                  row_end_o;
  logic [1:0]            pad_bytes_o;
  logic                  image_end_o;
  logic                  rejected_o;

  integer_pixel_upscaler_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .pixel_in_i  (pixel_in_i),
    .empty       (empty),
    .pop         (pop),
    .pixel_out_o (pixel_out_o),
    .last_o      (last_o),
    .row_end_o   (row_end_o),
    .pad_bytes_o (pad_bytes_o),
    .image_end_o (image_end_o),
    .rejected_o  (rejected_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic [PIXEL_W-1:0] line_copy [MAX_WIDTH];
  int unsigned        col_pos, rep_pos, row_pos;
  op_e                want_op;
  logic [3:0]         reg_scale;
  logic [12:0]        reg_width;
  logic [15:0]        reg_rows;

  px_res_t   pixels_due [$];
  px_res_t   step_copies [$];
  stim_row_t stim_tbl [$];

  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned errors = 0;
  int unsigned n_items = 0, n_results = 0, n_rejects = 0, n_images = 0, n_cfg = 0;
  int unsigned quiet = 0;

  function automatic int unsigned scale_used();
    if (reg_scale < 1) return 1;
    if (reg_scale > MAX_SCALE) return MAX_SCALE;
    return reg_scale;
  endfunction

  function automatic int unsigned width_used();
    if (reg_width < 1) return 1;
    if (reg_width > MAX_WIDTH) return MAX_WIDTH;
    return reg_width;
  endfunction

  function automatic int unsigned rows_used();
    return (reg_rows < 1) ? 1 : reg_rows;
  endfunction

  // Copies caused by one accepted item; fills step_copies and, for an in-phase item, advances the state.
  function automatic void upscale_step(op_e op, logic [PIXEL_W-1:0] pix_in);
    int unsigned s, w, nrows, pad;
    bit row_done, last_row, last_rep, img;
    logic [PIXEL_W-1:0] pix;
    px_res_t r;
    step_copies.delete();
    if (op != want_op) begin
      step_copies.push_back(REJECT_RES);
      return;
    end
    s = scale_used();
    w = width_used();
    nrows = rows_used();
    if (col_pos >= w) col_pos = w - 1;
    row_done = (col_pos + 1 >= w);
    last_row = (row_pos + 1 >= nrows);
    if (op == OP_SOURCE) begin
      line_copy[col_pos] = pix_in;
      pix = pix_in;
      last_rep = (s == 1);
    end else begin
      pix = line_copy[col_pos];
      last_rep = (rep_pos + 2 >= s);
    end
    img = row_done && last_row && last_rep;
    pad = (4 - (3 * w * s) % 4) % 4;
    for (int unsigned k = 0; k < s; k++) begin
      r.pixel     = pix;
      r.last      = (k + 1 == s);
      r.row_end   = r.last && row_done;
      r.pad       = r.row_end ? 2'(pad) : 2'd0;
      r.image_end = r.last && img;
      r.rejected  = 1'b0;
      step_copies.push_back(r);
    end
    if (!row_done) begin
      col_pos++;
    end else begin
      col_pos = 0;
      if (op == OP_SOURCE && !last_rep) begin
        want_op = OP_REPLAY;
        rep_pos = 0;
      end else begin
        if (op == OP_REPLAY) rep_pos++;
        if (last_rep) begin
          want_op = OP_SOURCE;
          rep_pos = 0;
          row_pos = last_row ? 0 : row_pos + 1;
        end
      end
    end
  endfunction

  function automatic void add_cfg(reg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t t;
    t = '{is_cfg: 1'b1, idx: idx, data: data, op: OP_SOURCE, pix: '0, typed: 1'b0, want: '0};
    stim_tbl.push_back(t);
  endfunction

  function automatic void add_item(op_e op, logic [PIXEL_W-1:0] pix, bit typed, px_res_t want);
    stim_row_t t;
    t = '{is_cfg: 1'b0, idx: REG_SCALE, data: '0, op: op, pix: pix, typed: typed, want: want};
    stim_tbl.push_back(t);
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_SCALE:        reg_scale = data[3:0];
      REG_SOURCE_WIDTH: reg_width = data[12:0];
      REG_SOURCE_ROWS:  reg_rows  = data[15:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic offer(input op_e op, input logic [PIXEL_W-1:0] pix, input bit typed,
                       input px_res_t want);
    while (!calm && $urandom_range(99) < 31) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push       <= 1'b1;
    op_i       <= op;
    pixel_in_i <= pix;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    upscale_step(op, pix);
    if (typed) pixels_due.push_back(want);
    else foreach (step_copies[k]) pixels_due.push_back(step_copies[k]);
    n_items++;
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic cmp_field(input string name, input logic [PIXEL_W-1:0] want,
                           input logic [PIXEL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // result side
  initial begin : drain_proc
    px_res_t want;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      pop <= calm || ($urandom_range(99) >= 31);
      @(posedge clk_i);
      if (pop && !empty) begin
        n_results++;
        if (rejected_o) n_rejects++;
        if (image_end_o) n_images++;
        if (pixels_due.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual pixel %h", $time,
                   pixel_out_o);
          errors++;
        end else begin
          want = pixels_due.pop_front();
          cmp_field("pixel_out", want.pixel, pixel_out_o);
          cmp_field("last", PIXEL_W'(want.last), PIXEL_W'(last_o));
          cmp_field("row_end", PIXEL_W'(want.row_end), PIXEL_W'(row_end_o));
          cmp_field("pad_bytes", PIXEL_W'(want.pad), PIXEL_W'(pad_bytes_o));
          cmp_field("image_end", PIXEL_W'(want.image_end), PIXEL_W'(image_end_o));
          cmp_field("rejected", PIXEL_W'(want.rejected), PIXEL_W'(rejected_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_integer_pixel_upscaler_core: done, errors");
        $finish;
      end
    end
  end

  initial begin : stim_proc
    int unsigned ph, nb, rand_items, cur_w, sel;
    logic [3:0]  sv;
    logic [12:0] wv;
    logic [15:0] rv;
    op_e         op;
    bit          cfg_open, big_done;

    col_pos = 0; rep_pos = 0; row_pos = 0; want_op = OP_SOURCE;
    reg_scale = 4'd1; reg_width = 13'd1; reg_rows = 16'd1;

    // reset defaults: scale, width, rows all one, so each source pixel is an image
    add_item(OP_REPLAY, 24'hABCDEF, 1'b1, REJECT_RES);
    add_item(OP_SOURCE, 24'hFFFFFF, 1'b1, '{24'hFFFFFF, 1'b1, 1'b1, 2'd1, 1'b1, 1'b0});
    add_item(OP_SOURCE, 24'h000000, 1'b1, '{24'h000000, 1'b1, 1'b1, 2'd1, 1'b1, 1'b0});
    add_cfg(REG_SCALE, 16'd2);
    add_cfg(REG_SOURCE_WIDTH, 16'd3);
    add_cfg(REG_SOURCE_ROWS, 16'd2);
    add_item(OP_SOURCE, 24'h123456, 1'b0, '0);
    add_item(OP_SOURCE, 24'h800001, 1'b0, '0);
    add_item(OP_SOURCE, 24'h7FFFFE, 1'b0, '0);
    add_item(OP_SOURCE, 24'h555555, 1'b1, REJECT_RES);
    repeat (3) add_item(OP_REPLAY, 24'hAAAAAA, 1'b0, '0);
    add_item(OP_SOURCE, 24'h0F0F0F, 1'b0, '0);
    add_item(OP_SOURCE, 24'hF0F0F0, 1'b0, '0);
    add_item(OP_SOURCE, 24'h00FF00, 1'b0, '0);
    repeat (3) add_item(OP_REPLAY, 24'h000000, 1'b0, '0);
    add_item(OP_REPLAY, 24'h333333, 1'b1, REJECT_RES);
    // out-of-range registers: scale clamps to max, width and rows of zero act as one
    add_cfg(REG_SCALE, 16'hFFFF);
    add_cfg(REG_SOURCE_WIDTH, 16'd0);
    add_cfg(REG_SOURCE_ROWS, 16'd0);
    add_item(OP_SOURCE, 24'hC3C3C3, 1'b0, '0);
    repeat (7) add_item(OP_REPLAY, 24'hFFFFFF, 1'b0, '0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cfg_open = 1'b0;
    foreach (stim_tbl[i]) begin
      if (stim_tbl[i].is_cfg) begin
        if (!cfg_open) settle();
        cfg_open = 1'b1;
        write_reg(stim_tbl[i].idx, stim_tbl[i].data);
      end else begin
        if (cfg_open) cfg_valid_i <= 1'b0;
        cfg_open = 1'b0;
        offer(stim_tbl[i].op, stim_tbl[i].pix, stim_tbl[i].typed, stim_tbl[i].want);
      end
    end

    rand_items = 0;
    ph = 0;
    big_done = 1'b0;
    while (rand_items < RANDOM_ITEMS) begin
      settle();
      calm = (ph == 4);
      if (ph == 2) hold_req = 1'b1;

      sel = (ph == 0) ? 1 : $urandom_range(9);
      if (ph == 0 || $urandom_range(9) < 7) begin
        sv = (sel == 0) ? 4'd0 : (sel == 1) ? 4'd8 : (sel == 2) ? 4'($urandom_range(15, 9)) :
             (sel == 3) ? 4'($urandom_range(7, 5)) : 4'($urandom_range(4, 1));
        write_reg(REG_SCALE, {12'($urandom()), sv});
      end

      // widening is only safe while source pixels are expected
      cur_w = width_used();
      sel = $urandom_range(9);
      if (!big_done && ph >= 1 && want_op == OP_SOURCE) sel = 1;
      if (cur_w > 64 || sel == 1 || $urandom_range(9) < 7) begin
        if (want_op == OP_REPLAY) begin
          wv = (sel == 0) ? 13'd0 : 13'($urandom_range(cur_w > 6 ? 6 : cur_w, 1));
        end else if (sel == 1 && cur_w <= 64) begin
          wv = big_done ? 13'($urandom_range(8191, 4096)) : 13'h1FFF;
          big_done = 1'b1;
        end else begin
          wv = (sel == 0) ? 13'd0 : 13'($urandom_range(6, 1));
        end
        write_reg(REG_SOURCE_WIDTH, {3'($urandom()), wv});
      end

      sel = (ph == 3) ? 1 : $urandom_range(9);
      if (ph == 3 || $urandom_range(9) < 7) begin
        rv = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF : 16'($urandom_range(3, 1));
        write_reg(REG_SOURCE_ROWS, rv);
      end
      cfg_valid_i <= 1'b0;

      nb = (width_used() > 64) ? 8 : $urandom_range(30, 15);
      for (int unsigned k = 0; k < nb; k++) begin
        op = ($urandom_range(99) < 88) ? want_op : op_e'(~want_op);
        offer(op, PIXEL_W'($urandom()), 1'b0, '0);
      end
      rand_items += nb;
      ph++;
    end
    calm = 1'b0;

    settle();
    repeat (8) @(posedge clk_i);
    $display("covered %0d items (%0d directed rows) over %0d random phases, %0d writes",
             n_items, stim_tbl.size(), ph, n_cfg);
    $display("checked %0d results: %0d rejected, %0d image ends", n_results, n_rejects,
             n_images);
    if (errors == 0) begin
      $display("tb_integer_pixel_upscaler_core: done, clean");
    end else begin
      $display("tb_integer_pixel_upscaler_core: done, errors");
    end
    $finish;
  end

endmodule
